// File: src/priority_schedule_wait_times_top_assert.svh
// Assertion macros used by the priority schedule top level.
`ifndef PRIORITY_SCHEDULE_WAIT_TIMES_TOP_ASSERT_SVH
`define PRIORITY_SCHEDULE_WAIT_TIMES_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSW_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("psw assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PSW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("psw assertion failed");

`endif

// File: src/psw_pkg.sv
// Shared types, constants and helper functions of the priority schedule block.
package psw_pkg;

    localparam int MAX_JOBS_DEF = 16;
    localparam int TAG_W        = 8;
    localparam int BURST_W      = 16;
    localparam int PRIO_W       = 8;
    localparam int WAIT_W       = 20;
    localparam int TOTAL_W      = 24;

    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // an input item is accepted
        logic start;  // the accepted item closes the set
        logic rd_i;   // read the record at the outer position
        logic cap_i;  // capture that record as the current candidate
        logic cmp;    // compare with the inner record and swap if needed
        logic emit;   // load the result registers
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic j_end;     // no inner positions remain for this pass
        logic j_last;    // the inner position is the last one of the set
        logic out_last;  // the held result is the final one of the set
    } t_sts;

    function automatic logic [WAIT_W-1:0] sat_wait(input logic [WAIT_W:0] val);
        sat_wait = val[WAIT_W] ? {WAIT_W{1'b1}} : val[WAIT_W-1:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOTAL_W:0] val);
        sat_total = val[TOTAL_W] ? {TOTAL_W{1'b1}} : val[TOTAL_W-1:0];
    endfunction

endpackage

// File: src/psw_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module psw_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/psw_ctrl.sv
// Controller state machine that sequences loading, sorting and emitting.
module psw_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last_job,
    input  logic          i_out_ready,
    input  psw_pkg::t_sts i_sts,
    output psw_pkg::t_cmd o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_I,
        S_LD_I,
        S_RD_J,
        S_CMP,
        S_EMIT,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD: begin
                if (i_in_valid && i_last_job) begin
                    n_state = S_RD_I;
                end
            end
            S_RD_I: begin
                n_state = S_LD_I;
            end
            S_LD_I: begin
                n_state = i_sts.j_end ? S_EMIT : S_RD_J;
            end
            S_RD_J: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = i_sts.j_last ? S_EMIT : S_RD_J;
            end
            S_EMIT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = i_sts.out_last ? S_LOAD : S_RD_I;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd       = '0;
        o_cmd.load  = (r_state == S_LOAD) && i_in_valid;
        o_cmd.start = (r_state == S_LOAD) && i_in_valid && i_last_job;
        o_cmd.rd_i  = (r_state == S_RD_I);
        o_cmd.cap_i = (r_state == S_LD_I);
        o_cmd.cmp   = (r_state == S_CMP);
        o_cmd.emit  = (r_state == S_EMIT);
    end

endmodule

// File: src/psw_dp.sv
// Datapath: job store, candidate register, counters, wait sums and result registers.
module psw_dp #(
    parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  psw_pkg::t_cmd                i_cmd,
    output psw_pkg::t_sts                o_sts,
    input  logic [psw_pkg::TAG_W-1:0]    i_job_tag,
    input  logic [psw_pkg::BURST_W-1:0]  i_burst_time,
    input  logic [psw_pkg::PRIO_W-1:0]   i_priority_level,
    output logic [psw_pkg::TAG_W-1:0]    o_out_tag,
    output logic [psw_pkg::BURST_W-1:0]  o_out_burst,
    output logic [psw_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [psw_pkg::WAIT_W-1:0]   o_wait_time,
    output logic [psw_pkg::TOTAL_W-1:0]  o_total_wait,
    output logic                         o_overflow_flag,
    output logic                         o_last_result
);

    localparam int AW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    logic [CW-1:0]              r_count;
    logic                       r_dropped;
    logic [CW-1:0]              r_i;
    logic [CW-1:0]              r_j;
    psw_pkg::t_job              r_cur;
    logic [psw_pkg::WAIT_W-1:0] r_wait;
    logic [psw_pkg::TOTAL_W-1:0] r_total;

    logic [psw_pkg::TAG_W-1:0]   r_o_tag;
    logic [psw_pkg::BURST_W-1:0] r_o_burst;
    logic [psw_pkg::PRIO_W-1:0]  r_o_prio;
    logic [psw_pkg::WAIT_W-1:0]  r_o_wait;
    logic [psw_pkg::TOTAL_W-1:0] r_o_total;
    logic                        r_o_ovf;
    logic                        r_o_last;

    psw_pkg::t_job               in_job;
    psw_pkg::t_job               rd_job;
    logic [psw_pkg::JOB_W-1:0]   rd_bits;
    psw_pkg::t_job               wr_job;
    logic                        full;
    logic                        swap;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [AW-1:0]               raddr;
    logic [CW-1:0]               j_inc;
    logic [CW-1:0]               i_inc;
    logic                        is_last;
    logic [psw_pkg::WAIT_W-1:0]  n_wait;
    logic [psw_pkg::TOTAL_W-1:0] n_total;

    assign in_job = '{tag: i_job_tag, burst: i_burst_time, prio: i_priority_level};
    assign rd_job = psw_pkg::t_job'(rd_bits);

    assign full    = (r_count == CW'(MAX_JOBS));
    assign swap    = (r_cur.prio > rd_job.prio);
    assign j_inc   = r_j + CW'(1);
    assign i_inc   = r_i + CW'(1);
    assign is_last = (i_inc == r_count);

    // The store is written by loading and by the swap of a compare step.
    assign we     = (i_cmd.load && !full) || (i_cmd.cmp && swap);
    assign waddr  = i_cmd.load ? r_count[AW-1:0] : r_j[AW-1:0];
    assign wr_job = i_cmd.load ? in_job : r_cur;
    assign raddr  = i_cmd.rd_i ? r_i[AW-1:0] : r_j[AW-1:0];

    assign n_total = psw_pkg::sat_total({1'b0, r_total} + psw_pkg::TOTAL_W'(r_wait));
    assign n_wait  = psw_pkg::sat_wait({1'b0, r_wait} + psw_pkg::WAIT_W'(r_cur.burst));

    psw_ram #(
        .DATA_W (psw_pkg::JOB_W),
        .DEPTH  (MAX_JOBS),
        .ADDR_W (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_job),
        .i_raddr (raddr),
        .o_rdata (rd_bits)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_dropped <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_o_last  <= 1'b0;
        end else begin
            if (i_cmd.emit && is_last) begin
                r_count   <= '0;
                r_dropped <= 1'b0;
            end else if (i_cmd.load) begin
                if (full) begin
                    r_dropped <= 1'b1;
                end else begin
                    r_count <= r_count + CW'(1);
                end
            end
            if (i_cmd.start) begin
                r_i <= '0;
            end else if (i_cmd.emit) begin
                r_i <= i_inc;
            end
            if (i_cmd.rd_i) begin
                r_j <= i_inc;
            end else if (i_cmd.cmp) begin
                r_j <= j_inc;
            end
            if (i_cmd.emit) begin
                r_o_last <= is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_i || (i_cmd.cmp && swap)) begin
            r_cur <= rd_job;
        end
        if (i_cmd.start) begin
            r_wait  <= '0;
            r_total <= '0;
        end else if (i_cmd.emit) begin
            r_wait  <= n_wait;
            r_total <= n_total;
        end
        if (i_cmd.emit) begin
            r_o_tag   <= r_cur.tag;
            r_o_burst <= r_cur.burst;
            r_o_prio  <= r_cur.prio;
            r_o_wait  <= r_wait;
            r_o_total <= n_total;
            r_o_ovf   <= r_dropped;
        end
    end

    assign o_sts.j_end    = (r_j == r_count);
    assign o_sts.j_last   = (j_inc == r_count);
    assign o_sts.out_last = r_o_last;

    assign o_out_tag       = r_o_tag;
    assign o_out_burst     = r_o_burst;
    assign o_out_priority  = r_o_prio;
    assign o_wait_time     = r_o_wait;
    assign o_total_wait    = r_o_total;
    assign o_overflow_flag = r_o_ovf;
    assign o_last_result   = r_o_last;

endmodule

// File: src/priority_schedule_wait_times_top.sv
// Top level of the non-preemptive priority scheduler with waiting-time sums.
//
// Usage: job items arrive on the input channel (i_in_valid / o_in_ready), one
// per cycle while the block is loading. Up to MAX_JOBS jobs are kept; later
// jobs of the same set are dropped and flagged in every result of that set.
// The item with i_last_job set closes the set. The block then stops taking
// items and runs an exchange sort over the job store, reading and then
// comparing each pair. The record that wins a pass is final for its
// position, so each result is emitted as soon as its pass ends.
// Results leave on the output channel (o_out_valid / i_out_ready), one item
// per scheduled job, with o_last_result set on the final one.
// Each result takes a read of the outer record, its capture, a read and a
// compare for each later position, and the emit step; the block takes no
// new items until the final result of the set is taken. The store has one
// read port, and each sort step reads, compares and writes back on a swap.
// A stalled receiver simply holds the result register and the sort waits.
// Reset empties the set and returns the block to loading; the job store
// itself needs no clearing since only entries of the current set are read.
module priority_schedule_wait_times_top #(
    parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [psw_pkg::TAG_W-1:0]    i_job_tag,
    input  logic [psw_pkg::BURST_W-1:0]  i_burst_time,
    input  logic [psw_pkg::PRIO_W-1:0]   i_priority_level,
    input  logic                         i_last_job,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [psw_pkg::TAG_W-1:0]    o_out_tag,
    output logic [psw_pkg::BURST_W-1:0]  o_out_burst,
    output logic [psw_pkg::PRIO_W-1:0]   o_out_priority,
    output logic [psw_pkg::WAIT_W-1:0]   o_wait_time,
    output logic [psw_pkg::TOTAL_W-1:0]  o_total_wait,
    output logic                         o_overflow_flag,
    output logic                         o_last_result
);

`include "priority_schedule_wait_times_top_assert.svh"

    psw_pkg::t_cmd cmd;
    psw_pkg::t_sts sts;

    // The controller only sequences; all storage and arithmetic sit in the datapath.
    psw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_job  (i_last_job),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid)
    );

    psw_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_job_tag        (i_job_tag),
        .i_burst_time     (i_burst_time),
        .i_priority_level (i_priority_level),
        .o_out_tag        (o_out_tag),
        .o_out_burst      (o_out_burst),
        .o_out_priority   (o_out_priority),
        .o_wait_time      (o_wait_time),
        .o_total_wait     (o_total_wait),
        .o_overflow_flag  (o_overflow_flag),
        .o_last_result    (o_last_result)
    );

    // Loading and emitting never overlap.
    `PSW_ASSERT_IMPL(a_load_emit_excl, o_in_ready, !o_out_valid)
    // Closing a set stops intake right away.
    `PSW_ASSERT_NEXT(a_close_stops_in, o_in_ready && i_in_valid && i_last_job, !o_in_ready)
    // Delivering the final result reopens intake in the next cycle.
    `PSW_ASSERT_NEXT(a_last_reopens, o_out_valid && i_out_ready && o_last_result, o_in_ready)
    // A result held by a stalled receiver stays valid with its total wait unchanged.
    `PSW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_total_wait))

endmodule
